@@ hw/rtl/tct_pkg.sv @@
// Shared types and constants for the timeout callback table.
package tct_pkg;

    localparam int NUM_ENTRIES    = 8;
    localparam int MAX_REPORTS    = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int IDX_W          = $clog2(NUM_ENTRIES);
    localparam int CNT_W          = $clog2(NUM_ENTRIES + 1);
    localparam int RPT_W          = $clog2(MAX_REPORTS + 1);
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam logic [7:0] ANY_MENU_RESET = 8'hFF;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_ADD     = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;
    localparam logic [1:0] CMD_SERVICE = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ADD,
        OP_CANCEL,
        OP_SERVICE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  callback_id;
        logic [31:0] delay_ms;
        logic [7:0]  target_menu;
        logic        update_existing;
        logic [7:0]  current_menu;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_ADD,
        ST_CANCEL,
        ST_SVC
    } state_t;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_WRITE,
        TBL_INSERT,
        TBL_REMOVE
    } tbl_op_t;

endpackage

@@ hw/rtl/tct_front.sv @@
// Front end: accepts input beats, decodes the command and queues it for the back end.
module tct_front
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  callback_id,
    input  logic [31:0] delay_ms,
    input  logic [7:0]  target_menu,
    input  logic        update_existing,
    input  logic [7:0]  current_menu,
    output logic        q_valid,
    output cmd_t        q_data,
    input  logic        q_pop
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    cmd_t              dec;

    always_comb
    begin
        dec.callback_id     = callback_id;
        dec.delay_ms        = delay_ms;
        dec.target_menu     = target_menu;
        dec.update_existing = update_existing;
        dec.current_menu    = current_menu;
        case (cmd)
            CMD_TICK:    dec.op = OP_TICK;
            CMD_ADD:     dec.op = OP_ADD;
            CMD_CANCEL:  dec.op = OP_CANCEL;
            CMD_SERVICE: dec.op = OP_SERVICE;
            default:     dec.op = OP_TICK;
        endcase
    end

    assign in_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != '0;
    assign q_data   = mem_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

@@ hw/rtl/tct_back.sv @@
// Back end: timer table, ms counter, result register; scans one slot per cycle when not stalled.
module tct_back
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        q_valid,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        op_ok,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic        last
);

    logic              valid_reg [NUM_ENTRIES];
    logic [7:0]        id_reg    [NUM_ENTRIES];
    logic [7:0]        menu_reg  [NUM_ENTRIES];
    logic [31:0]       start_reg [NUM_ENTRIES];
    logic [31:0]       delay_reg [NUM_ENTRIES];

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [RPT_W-1:0]  n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_id_reg, pend_id_next;
    logic [31:0]       now_reg, now_next;
    logic [7:0]        any_menu_reg;

    logic              out_valid_reg;
    logic              op_ok_reg;
    logic              fired_reg;
    logic [7:0]        fired_id_reg;
    logic              last_reg;

    logic [IDX_W-1:0]  cur_idx;
    logic              at_end;
    logic              sel_valid;
    logic [7:0]        sel_id;
    logic [7:0]        sel_menu;
    logic [31:0]       sel_age;
    logic              expired;
    logic              menu_match;
    logic              out_free;
    logic              emit;
    logic              emit_ok;
    logic              emit_fired;
    logic [7:0]        emit_id;
    logic              emit_last;
    tbl_op_t           tbl_op;

    assign cur_idx    = idx_reg[IDX_W-1:0];
    assign at_end     = idx_reg == CNT_W'(NUM_ENTRIES);
    assign sel_valid  = valid_reg[cur_idx];
    assign sel_id     = id_reg[cur_idx];
    assign sel_menu   = menu_reg[cur_idx];
    assign sel_age    = now_reg - start_reg[cur_idx];
    assign expired    = sel_age >= delay_reg[cur_idx];
    assign menu_match = (sel_menu == any_menu_reg) || (sel_menu == cmd_reg.current_menu);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        now_next        = now_reg;
        q_pop           = 1'b0;
        tbl_op          = TBL_NONE;
        emit            = 1'b0;
        emit_ok         = 1'b0;
        emit_fired      = 1'b0;
        emit_id         = '0;
        emit_last       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_data;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (q_data.op)
                        OP_TICK:    state_next = ST_TICK;
                        OP_ADD:     state_next = ST_ADD;
                        OP_CANCEL:  state_next = ST_CANCEL;
                        OP_SERVICE: state_next = ST_SVC;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TICK:
            begin
                emit = 1'b1;
                if (out_free)
                begin
                    now_next   = now_reg + 32'd1;
                    state_next = ST_IDLE;
                end
            end

            ST_ADD:
            begin
                if (at_end)
                begin
                    emit = 1'b1;
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!sel_valid ||
                         (sel_id == cmd_reg.callback_id && cmd_reg.update_existing))
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                    if (out_free)
                    begin
                        tbl_op     = TBL_WRITE;
                        state_next = ST_IDLE;
                    end
                end
                else if (expired)
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                    if (out_free)
                    begin
                        tbl_op     = TBL_INSERT;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_CANCEL:
            begin
                if (at_end)
                begin
                    emit = 1'b1;
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (sel_valid && sel_id == cmd_reg.callback_id &&
                         sel_menu == cmd_reg.target_menu)
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                    if (out_free)
                    begin
                        tbl_op     = TBL_REMOVE;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_SVC:
            begin
                if (at_end || !sel_valid ||
                    (expired && menu_match && n_reg >= RPT_W'(MAX_REPORTS)))
                begin
                    // end of scan: flush the held report, or give the empty beat
                    emit       = 1'b1;
                    emit_ok    = pend_valid_reg;
                    emit_fired = pend_valid_reg;
                    emit_id    = pend_valid_reg ? pend_id_reg : 8'd0;
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (expired && menu_match)
                begin
                    // a report is held back one step so the last one can be marked
                    emit       = pend_valid_reg;
                    emit_ok    = 1'b1;
                    emit_fired = 1'b1;
                    emit_id    = pend_id_reg;
                    emit_last  = 1'b0;
                    if (out_free || !pend_valid_reg)
                    begin
                        tbl_op          = TBL_REMOVE;
                        pend_valid_next = 1'b1;
                        pend_id_next    = sel_id;
                        n_next          = n_reg + RPT_W'(1);
                    end
                end
                else if (expired)
                begin
                    tbl_op = TBL_REMOVE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            now_reg        <= '0;
            any_menu_reg   <= ANY_MENU_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            now_reg        <= now_next;
            if (cfg_wr_en)
            begin
                any_menu_reg <= cfg_wr_data;
            end
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pend_id_reg <= pend_id_next;
        if (emit && out_free)
        begin
            op_ok_reg    <= emit_ok;
            fired_reg    <= emit_fired;
            fired_id_reg <= emit_id;
            last_reg     <= emit_last;
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_slot
        logic hit;
        logic above;

        assign hit   = cur_idx == IDX_W'(g);
        assign above = IDX_W'(g) > cur_idx;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                case (tbl_op)
                    TBL_WRITE:
                    begin
                        if (hit)
                        begin
                            valid_reg[g] <= 1'b1;
                        end
                    end
                    TBL_INSERT:
                    begin
                        if (hit)
                        begin
                            valid_reg[g] <= 1'b1;
                        end
                        else if (above)
                        begin
                            if (g > 0)
                            begin
                                valid_reg[g] <= valid_reg[(g > 0) ? g - 1 : 0];
                            end
                        end
                    end
                    TBL_REMOVE:
                    begin
                        if (hit || above)
                        begin
                            if (g < NUM_ENTRIES - 1)
                            begin
                                valid_reg[g] <= valid_reg[(g < NUM_ENTRIES - 1) ? g + 1 : g];
                            end
                            else
                            begin
                                valid_reg[g] <= 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        always_ff @(posedge clk)
        begin
            case (tbl_op)
                TBL_WRITE, TBL_INSERT:
                begin
                    if (hit)
                    begin
                        id_reg[g]    <= cmd_reg.callback_id;
                        menu_reg[g]  <= cmd_reg.target_menu;
                        start_reg[g] <= now_reg;
                        delay_reg[g] <= cmd_reg.delay_ms;
                    end
                    else if (above && tbl_op == TBL_INSERT && g > 0)
                    begin
                        id_reg[g]    <= id_reg[(g > 0) ? g - 1 : 0];
                        menu_reg[g]  <= menu_reg[(g > 0) ? g - 1 : 0];
                        start_reg[g] <= start_reg[(g > 0) ? g - 1 : 0];
                        delay_reg[g] <= delay_reg[(g > 0) ? g - 1 : 0];
                    end
                end
                TBL_REMOVE:
                begin
                    if ((hit || above) && g < NUM_ENTRIES - 1)
                    begin
                        id_reg[g]    <= id_reg[(g < NUM_ENTRIES - 1) ? g + 1 : g];
                        menu_reg[g]  <= menu_reg[(g < NUM_ENTRIES - 1) ? g + 1 : g];
                        start_reg[g] <= start_reg[(g < NUM_ENTRIES - 1) ? g + 1 : g];
                        delay_reg[g] <= delay_reg[(g < NUM_ENTRIES - 1) ? g + 1 : g];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign op_ok     = op_ok_reg;
    assign fired     = fired_reg;
    assign fired_id  = fired_id_reg;
    assign last      = last_reg;

endmodule

@@ hw/rtl/timeout_callback_table.sv @@
// Top level of the timeout callback table.
// Keeps up to NUM_ENTRIES (8) pending timeouts packed at the front of a table.
// Commands enter a two-beat queue, so new beats are taken while the engine
// works; the engine scans the table one slot per clock unless a result
// waiting on out_ready stalls it. A command leaves the queue, runs on the
// engine and ends with its final result, held in the result register until
// out_ready. A service command returns one beat per fired callback in table
// order, last marking the final one, or a single empty beat if none fired.
// cfg_wr_data sets the wildcard menu code (255 after reset); write it only
// while the block is idle.
module timeout_callback_table
    import tct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  callback_id,
    input  logic [31:0] delay_ms,
    input  logic [7:0]  target_menu,
    input  logic        update_existing,
    input  logic [7:0]  current_menu,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        op_ok,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic        last
);

    logic q_valid;
    cmd_t q_data;
    logic q_pop;

    tct_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .callback_id     (callback_id),
        .delay_ms        (delay_ms),
        .target_menu     (target_menu),
        .update_existing (update_existing),
        .current_menu    (current_menu),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop)
    );

    tct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .op_ok       (op_ok),
        .fired       (fired),
        .fired_id    (fired_id),
        .last        (last)
    );

endmodule
